// File: src/sha256_message_digest_assert.svh
// assertion macros shared by the sha-256 digest rtl
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SHAMD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SHAMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/shamd_pkg.sv
// types, constants and round functions of the sha-256 digest block
`default_nettype none

package shamd_pkg;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// commands from the message sequencer to the compression unit
	typedef struct packed {
		logic       push;
		logic [7:0] push_byte;
		logic       start;
		logic       init;
	} core_cmd_t;

	typedef struct packed {
		logic            busy;
		logic [3:0][63:0] digest;
	} core_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
		return (x >> s) | (x << (32 - s));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

`default_nettype wire

// File: src/shamd_if.sv
// valid/ready channel interfaces for message bytes and digest parts
`default_nettype none

interface shamd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_message, output ready);
endinterface

interface shamd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_part;
	logic [1:0]  part_index;
	logic        last_part;

	modport source (output valid, output digest_part, output part_index,
		output last_part, input ready);
	modport sink (input valid, input digest_part, input part_index,
		input last_part, output ready);
endinterface

`default_nettype wire

// File: src/shamd_core.sv
// sha-256 compression unit: block shift register, one round per cycle, hash state
`default_nettype none
`include "sha256_message_digest_assert.svh"

module shamd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire shamd_pkg::core_cmd_t  cmd,
	output shamd_pkg::core_stat_t   stat
);

	localparam logic [1:0] CORE_IDLE  = 2'd0;
	localparam logic [1:0] CORE_ROUND = 2'd1;
	localparam logic [1:0] CORE_FINAL = 2'd2;

	logic [1:0]   state_q;
	logic [5:0]   rnd_q;
	logic [511:0] blk_q;
	logic [31:0]  hash_q [8];
	logic [31:0]  wv_q [8];

	logic [31:0] w0, w1, w9, w14;
	logic [31:0] sched_new;
	logic [31:0] t1, t2;
	logic [31:0] ch, mj;

	// block words, oldest in the top bits; the same register is the schedule window
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];

	assign sched_new = shamd_pkg::ssig1(w14) + w9 + shamd_pkg::ssig0(w1) + w0;

	assign ch = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign mj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1 = wv_q[7] + shamd_pkg::bsig1(wv_q[4]) + ch + shamd_pkg::ROUND_K[rnd_q] + w0;
	assign t2 = shamd_pkg::bsig0(wv_q[0]) + mj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
			rnd_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= shamd_pkg::INIT_H[i];
			end
		end else begin
			unique case (state_q)
				CORE_IDLE: begin
					if (cmd.init) begin
						for (int i = 0; i < 8; i++) begin
							hash_q[i] <= shamd_pkg::INIT_H[i];
						end
					end
					if (cmd.start) begin
						rnd_q   <= '0;
						state_q <= CORE_ROUND;
					end
				end
				CORE_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= CORE_FINAL;
					end
				end
				CORE_FINAL: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + wv_q[i];
					end
					state_q <= CORE_IDLE;
				end
				default: begin
					state_q <= CORE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q <= {blk_q[503:0], cmd.push_byte};
		end else if (state_q == CORE_ROUND) begin
			blk_q <= {blk_q[479:0], sched_new};
		end
		if (state_q == CORE_IDLE && cmd.start) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= hash_q[i];
			end
		end else if (state_q == CORE_ROUND) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	always_comb begin
		stat.busy = (state_q != CORE_IDLE);
		for (int k = 0; k < 4; k++) begin
			stat.digest[k] = {hash_q[2 * k], hash_q[2 * k + 1]};
		end
	end

	`SHAMD_ASSERT_IMPLY(a_start_only_idle, cmd.start, state_q == CORE_IDLE, "start while compressing")
	`SHAMD_ASSERT_IMPLY(a_push_only_idle, cmd.push, state_q == CORE_IDLE, "byte pushed into active schedule")
	`SHAMD_ASSERT_NEXT(a_round_advance, state_q == CORE_ROUND && rnd_q != 6'd63,
		state_q == CORE_ROUND && rnd_q == $past(rnd_q) + 6'd1, "round counter skipped")

endmodule

`default_nettype wire

// File: src/sha256_message_digest.sv
// sha-256 message digest: byte input, padding sequencer, four-part digest output
//
// in_ch carries one item per transfer: data_byte, has_byte (data_byte belongs
// to the message) and end_of_message (final item of the message). out_ch
// returns the 256-bit digest as four 64-bit big-endian parts, part_index 0..3,
// last_part set on part 3.
// The item that completes a 64-byte block also starts the compression on the
// single shared round unit: 64 rounds, then the hash update, then a handover
// back to the input. ready is low while a block is compressed, while padding
// is shifted in and while the digest is delivered. After end_of_message the
// padding bytes enter one per cycle up to the end of the block, followed by
// a compression; when the length field does not fit, a second padded block
// follows. The first digest part is offered the cycle after the last
// compression ends.
// The parts are held in registers: a stalled receiver simply keeps the
// current part on out_ch until it is taken. After part 3 transfers the hash
// state returns to its initial value and the byte count to zero.
// Reset puts the hash state at the initial values, clears the byte count and
// leaves the block idle and ready.
`default_nettype none
`include "sha256_message_digest_assert.svh"

module sha256_message_digest (
	input  wire logic  clk,
	input  wire logic  arst_n,
	shamd_in_if.sink   in_ch,
	shamd_out_if.source out_ch
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WAIT  = 3'd1;
	localparam logic [2:0] ST_PAD   = 3'd2;
	localparam logic [2:0] ST_PWAIT = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]  state_q;
	logic [60:0] cnt_q;
	logic        fin_q;
	logic [5:0]  pp_q;
	logic        mark_q;
	logic        extra_q;
	logic        last_q;
	logic [1:0]  idx_q;

	shamd_pkg::core_cmd_t  cmd;
	shamd_pkg::core_stat_t stat;

	logic        in_fire;
	logic        out_fire;
	logic [5:0]  pos_n;
	logic [63:0] bit_len;
	logic [63:0] len_sh;
	logic [7:0]  pad_byte;

	shamd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_fire      = in_ch.valid & in_ch.ready;
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_fire     = out_ch.valid & out_ch.ready;

	assign out_ch.digest_part = stat.digest[idx_q];
	assign out_ch.part_index  = idx_q;
	assign out_ch.last_part   = (idx_q == 2'd3);

	// position of the pad mark in the current block
	assign pos_n = in_ch.has_byte ? (cnt_q[5:0] + 6'd1) : cnt_q[5:0];

	// length bytes go out most significant first, at block positions 56..63
	assign bit_len = {cnt_q, 3'b000};
	assign len_sh  = bit_len << {pp_q[2:0], 3'b000};

	always_comb begin
		if (mark_q) begin
			pad_byte = shamd_pkg::PAD_MARK;
		end else if (pp_q >= shamd_pkg::LEN_POS && !extra_q) begin
			pad_byte = len_sh[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && in_ch.has_byte) begin
					cmd.push      = 1'b1;
					cmd.push_byte = in_ch.data_byte;
					cmd.start     = (cnt_q[5:0] == 6'd63);
				end
			end
			ST_PAD: begin
				cmd.push      = 1'b1;
				cmd.push_byte = pad_byte;
				cmd.start     = (pp_q == 6'd63);
			end
			ST_OUT: begin
				cmd.init = out_fire && (idx_q == 2'd3);
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			pp_q    <= '0;
			mark_q  <= 1'b0;
			extra_q <= 1'b0;
			last_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_ch.has_byte) begin
							cnt_q <= cnt_q + 61'd1;
						end
						fin_q   <= in_ch.end_of_message;
						pp_q    <= pos_n;
						mark_q  <= 1'b1;
						extra_q <= (pos_n >= shamd_pkg::LEN_POS);
						if (in_ch.has_byte && cnt_q[5:0] == 6'd63) begin
							state_q <= ST_WAIT;
						end else if (in_ch.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_WAIT: begin
					if (!stat.busy) begin
						state_q <= fin_q ? ST_PAD : ST_IDLE;
					end
				end
				ST_PAD: begin
					mark_q <= 1'b0;
					pp_q   <= pp_q + 6'd1;
					if (pp_q == 6'd63) begin
						last_q  <= !extra_q;
						extra_q <= 1'b0;
						state_q <= ST_PWAIT;
					end
				end
				ST_PWAIT: begin
					if (!stat.busy) begin
						idx_q   <= '0;
						state_q <= last_q ? ST_OUT : ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SHAMD_ASSERT_IMPLY(a_ready_core_idle, in_ch.ready, !stat.busy, "ready during compression")
	`SHAMD_ASSERT_NEXT(a_last_part_idle, out_fire && out_ch.last_part, state_q == ST_IDLE && cnt_q == '0,
		"not back to idle after last part")
	`SHAMD_ASSERT_NEXT(a_pad_block_compress, state_q == ST_PAD && pp_q == 6'd63,
		stat.busy && state_q == ST_PWAIT, "padded block not compressed")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the sha-256 message digest block
`timescale 1ns / 100ps

module tb_top;

	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 250;
	localparam int RANDOM_ITEMS = 150;
	localparam int ITEM_CAP     = 175;

	typedef struct {
		logic [63:0] bits;
		logic [1:0]  idx;
		logic        last;
	} quarter_t;

	class sha256_predictor;
		logic [31:0] hw [8];
		logic [7:0]  blk [64];
		logic [60:0] nbytes;
		quarter_t    pending_parts [$];
		int          errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			foreach (hw[i]) hw[i] = shamd_pkg::INIT_H[i];
			nbytes = '0;
		endfunction

		function logic [31:0] ror(logic [31:0] x, int s);
			return (x >> s) | (x << (32 - s));
		endfunction

		function void compress();
			logic [31:0] w [64];
			logic [31:0] r [8];
			logic [31:0] t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++)
				w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
					+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
			foreach (r[i]) r[i] = hw[i];
			for (int i = 0; i < 64; i++) begin
				t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
					+ ((r[4] & r[5]) ^ (~r[4] & r[6])) + shamd_pkg::ROUND_K[i] + w[i];
				t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
					+ ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
				r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
				r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
			end
			foreach (hw[i]) hw[i] = hw[i] + r[i];
		endfunction

		// one accepted input transfer
		function void take_item(logic [7:0] b, logic has, logic eom);
			logic [63:0] bit_len;
			int pos;
			quarter_t q;
			if (has) begin
				blk[nbytes[5:0]] = b;
				nbytes = nbytes + 1'b1;
				if (nbytes[5:0] == 6'd0) compress();
			end
			if (!eom) return;
			bit_len = {nbytes, 3'b000};
			pos = nbytes[5:0];
			blk[pos] = shamd_pkg::PAD_MARK;
			pos++;
			// length field does not fit, pad out an extra block
			if (pos > shamd_pkg::LEN_POS) begin
				while (pos < 64) begin
					blk[pos] = 8'h00;
					pos++;
				end
				compress();
				pos = 0;
			end
			while (pos < shamd_pkg::LEN_POS) begin
				blk[pos] = 8'h00;
				pos++;
			end
			for (int k = 0; k < 8; k++)
				blk[shamd_pkg::LEN_POS + k] = bit_len[63 - 8*k -: 8];
			compress();
			for (int k = 0; k < 4; k++) begin
				q.bits = {hw[2*k], hw[2*k+1]};
				q.idx  = k[1:0];
				q.last = (k == 3);
				pending_parts = {pending_parts, q};
			end
			restart();
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_part(logic [63:0] bits, logic [1:0] idx, logic last);
			quarter_t q;
			if (pending_parts.size() == 0) begin
				report($sformatf("unexpected digest part %h idx %0d", bits, idx));
				return;
			end
			q = pending_parts.pop_front();
			if (bits !== q.bits || idx !== q.idx || last !== q.last)
				report($sformatf("part got %h/%0d/%b want %h/%0d/%b",
					bits, idx, last, q.bits, q.idx, q.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic calm;
	logic hold_req;
	logic hold_done;
	int   item_count;

	sha256_predictor digest_model = new();

	shamd_in_if  in_ch ();
	shamd_out_if out_ch ();

	sha256_message_digest dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("sha256_message_digest regression: fail");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
		while (!calm && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.data_byte      <= b;
		in_ch.has_byte       <= has;
		in_ch.end_of_message <= eom;
		do @(posedge clk); while (!in_ch.ready);
		digest_model.take_item(b, has, eom);
		item_count++;
	endtask

	// message of len bytes with some ignored items mixed in
	task automatic send_message(input int len);
		logic joined;
		joined = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, joined && (i == len - 1));
		end
		if (!joined)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// digest receiver, with one long hold-off so the input backs up
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ch.ready <= calm || ($urandom_range(99) >= 21);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			digest_model.check_part(out_ch.digest_part, out_ch.part_index, out_ch.last_part);
	end

	initial begin
		int r;
		int len;
		int longs [5] = '{55, 56, 57, 63, 64};
		int multi [3] = '{65, 119, 120};
		calm = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		item_count = 0;
		arst_n               <= 1'b0;
		in_ch.valid          <= 1'b0;
		in_ch.data_byte      <= 8'h00;
		in_ch.has_byte       <= 1'b0;
		in_ch.end_of_message <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message
		send_item(8'h00, 1'b0, 1'b1);
		// single byte carrying the end flag, both extremes
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		// ignored item, one byte, then an end with a stray byte value
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h5a, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		// "abc" with the end on the last byte
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// padding-mark value as data, noise in between
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b0);
		send_item(8'h7f, 1'b1, 1'b0);
		send_item(8'h01, 1'b0, 1'b1);

		hold_req = 1'b1;
		while (item_count < RANDOM_ITEMS) begin
			calm = (item_count >= 70) && (item_count < 115);
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(12);
			else if (r < 92)
				len = longs[$urandom_range(4)];
			else
				len = multi[$urandom_range(2)];
			// keep the total close to the planned item count
			if (item_count + len > ITEM_CAP)
				len = ITEM_CAP - item_count;
			send_message(len);
		end
		calm = 1'b0;
		in_ch.valid <= 1'b0;

		while (digest_model.pending_parts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (digest_model.pending_parts.size() != 0)
			digest_model.report($sformatf("%0d digest parts never arrived",
				digest_model.pending_parts.size()));
		if (digest_model.errors == 0)
			$display("sha256_message_digest regression: pass");
		else
			$display("sha256_message_digest regression: fail");
		$finish;
	end

endmodule
